// ===== design/ctcr_pkg.sv =====
package ctcr_pkg;

   localparam int DEPTH        = 256;
   localparam int FAULT_WINDOW = 16;
   localparam int CHUNK        = 8;
   localparam int RECORD_WIDTH = 64;
   localparam int QUEUE_DEPTH  = 2;

   // Field widths of the two channels.
   localparam int OP_W        = 3;
   localparam int WORD_W      = 64;
   localparam int REASON_W    = 8;
   localparam int STAMP_W     = 32;
   localparam int KIND_W      = 3;
   localparam int POS_W       = 8;
   localparam int TOTAL_W     = 9;
   localparam int CHUNK_NUM_W = 6;
   localparam int STORED_W    = 9;

   // Internal widths derived from the configuration.
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int CHUNKS_MAX  = (DEPTH + CHUNK - 1) / CHUNK;
   localparam int CHUNK_CNT_W = $clog2(CHUNKS_MAX + 1);
   localparam int RUN_MAX     = (FAULT_WINDOW > CHUNK) ? FAULT_WINDOW : CHUNK;
   localparam int RUN_W       = $clog2(RUN_MAX + 1);
   localparam int FROM_W      = $clog2(DEPTH + CHUNK + 1);
   localparam int SUM_W       = PTR_W + 1;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_RECORD = 3'd0,
      OP_FAULT  = 3'd1,
      OP_WINDOW = 3'd2,
      OP_DUMP   = 3'd3,
      OP_CHUNK  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CMD_RECORD,
      CMD_FAULT,
      CMD_WINDOW,
      CMD_DUMP,
      CMD_CHUNK
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FAULT_ACK   = 3'd0,
      KIND_WINDOW      = 3'd1,
      KIND_DUMP_REC    = 3'd2,
      KIND_DUMP_START  = 3'd3,
      KIND_NOT_DUMPING = 3'd4
   } kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [WORD_W-1:0]   record_word;
      logic [REASON_W-1:0] fault_cause;
      logic [STAMP_W-1:0]  fault_time;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [WORD_W-1:0]      record_out;
      logic                   record_valid;
      logic [POS_W-1:0]       position;
      logic [TOTAL_W-1:0]     total_count;
      logic [CHUNK_NUM_W-1:0] chunk_number;
      logic [STORED_W-1:0]    stored_count;
      logic [REASON_W-1:0]    latched_reason;
      logic [STAMP_W-1:0]     latched_time;
      logic                   fault_pending;
      logic                   more_chunks;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [RECORD_WIDTH-1:0] word;
      logic [REASON_W-1:0]     reason;
      logic [STAMP_W-1:0]      stamp;
   } queue_entry_type;

   typedef struct packed {
      logic            push;
      queue_entry_type entry;
   } q_write_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } q_read_type;

endpackage

// ===== design/ctcr_front.sv =====
module ctcr_front (
   input  logic                  start,
   input  ctcr_pkg::req_type     req,
   input  logic                  queue_full,
   output logic                  busy,
   output ctcr_pkg::q_write_type qw
);
   import ctcr_pkg::*;

   logic known_op;
   cmd_type cmd;

   always_comb begin
      known_op = 1'b1;
      cmd      = CMD_RECORD;
      unique case (op_type'(req.operation))
         OP_RECORD: cmd = CMD_RECORD;
         OP_FAULT:  cmd = CMD_FAULT;
         OP_WINDOW: cmd = CMD_WINDOW;
         OP_DUMP:   cmd = CMD_DUMP;
         OP_CHUNK:  cmd = CMD_CHUNK;
         default:   known_op = 1'b0;
      endcase
   end

   assign busy = queue_full;

   // Unused operation codes are taken and dropped here; they never reach the back end.
   always_comb begin
      qw.push         = start && !queue_full && known_op;
      qw.entry.cmd    = cmd;
      qw.entry.word   = req.record_word[RECORD_WIDTH-1:0];
      qw.entry.reason = req.fault_cause;
      qw.entry.stamp  = req.fault_time;
   end

endmodule

// ===== design/ctcr_queue.sv =====
module ctcr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  ctcr_pkg::q_write_type qw,
   input  logic                  pop,
   output ctcr_pkg::q_read_type  qr,
   output logic                  full
);
   import ctcr_pkg::*;

   queue_entry_type entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign do_pop = pop && (count_ff != '0);
   assign full   = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (qw.push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (qw.push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !qw.push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (qw.push) begin
         entries_ff[wr_ptr_ff] <= qw.entry;
      end
   end

   always_comb begin
      qr.valid = (count_ff != '0);
      qr.entry = entries_ff[rd_ptr_ff];
   end

endmodule

// ===== design/ctcr_back.sv =====
module ctcr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ctcr_pkg::q_read_type qr,
   output logic                 pop,
   output logic                 rsp_strobe,
   output ctcr_pkg::rsp_type    rsp
);
   import ctcr_pkg::*;

   logic [RECORD_WIDTH-1:0] ring_mem [DEPTH];
   logic [RECORD_WIDTH-1:0] rd_data_ff;

   back_state_type state_ff, state_in;

   logic [PTR_W-1:0]       wp_ff, wp_in;
   logic                   wrapped_ff, wrapped_in;
   logic                   pending_ff, pending_in;
   logic [REASON_W-1:0]    reason_ff, reason_in;
   logic [STAMP_W-1:0]     held_stamp_ff, held_stamp_in;
   logic                   dump_active_ff, dump_active_in;
   logic [CHUNK_CNT_W-1:0] next_chunk_ff, next_chunk_in;
   logic [CHUNK_CNT_W-1:0] chunk_total_ff, chunk_total_in;

   kind_type               run_kind_ff, run_kind_in;
   logic [PTR_W-1:0]       run_addr_ff, run_addr_in;
   logic [RUN_W-1:0]       run_idx_ff, run_idx_in;
   logic [RUN_W-1:0]       run_cnt_ff, run_cnt_in;
   logic                   run_has_rec_ff, run_has_rec_in;
   logic [TOTAL_W-1:0]     run_total_ff, run_total_in;
   logic [CHUNK_NUM_W-1:0] run_chunk_ff, run_chunk_in;
   logic                   run_more_ff, run_more_in;

   logic    out_valid_ff;
   rsp_type out_meta_ff;

   logic                   emit;
   logic                   run_last;
   logic                   mem_we;
   logic [COUNT_W-1:0]     stored;
   logic [RUN_W-1:0]       take;
   logic [FROM_W-1:0]      n_wide;
   logic [FROM_W-1:0]      from;
   logic [FROM_W-1:0]      remain;
   logic [RUN_W-1:0]       chunk_cnt;
   logic [CHUNK_CNT_W-1:0] chunk_num;
   logic                   chunk_more;
   logic [CHUNK_CNT_W-1:0] dump_total;
   logic [FROM_W-1:0]      win_off;
   logic [FROM_W-1:0]      dump_off;
   logic [SUM_W-1:0]       win_sum;
   logic [SUM_W-1:0]       dump_sum;
   logic [PTR_W-1:0]       win_base;
   logic [PTR_W-1:0]       dump_base;

   assign stored   = wrapped_ff ? COUNT_W'(DEPTH) : COUNT_W'(wp_ff);
   assign run_last = (run_idx_ff == run_cnt_ff - RUN_W'(1));

   // Readout geometry; the start address of a readout is the write pointer minus its
   // distance back, taken modulo the ring size with one compare and subtract.
   always_comb begin
      n_wide = FROM_W'(stored);
      if (int'(stored) < FAULT_WINDOW) begin
         take = RUN_W'(stored);
      end else begin
         take = RUN_W'(FAULT_WINDOW);
      end
      win_off = FROM_W'(DEPTH) - FROM_W'(take);
      win_sum = SUM_W'(wp_ff) + SUM_W'(win_off);
      if (win_sum >= SUM_W'(DEPTH)) begin
         win_sum = win_sum - SUM_W'(DEPTH);
      end
      win_base = win_sum[PTR_W-1:0];

      from   = FROM_W'(next_chunk_ff) * FROM_W'(CHUNK);
      remain = (n_wide > from) ? n_wide - from : '0;
      if (int'(remain) > CHUNK) begin
         chunk_cnt = RUN_W'(CHUNK);
      end else begin
         chunk_cnt = RUN_W'(remain);
      end
      chunk_num  = next_chunk_ff + CHUNK_CNT_W'(1);
      chunk_more = (chunk_num < chunk_total_ff);
      dump_off   = FROM_W'(DEPTH) - n_wide + from;
      dump_sum   = SUM_W'(wp_ff) + SUM_W'(dump_off);
      if (dump_sum >= SUM_W'(DEPTH)) begin
         dump_sum = dump_sum - SUM_W'(DEPTH);
      end
      dump_base  = dump_sum[PTR_W-1:0];

      dump_total = CHUNK_CNT_W'((n_wide + FROM_W'(CHUNK - 1)) / CHUNK);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (qr.valid && qr.entry.cmd != CMD_RECORD) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (run_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop  = (state_ff == BK_IDLE) && qr.valid;
      emit = (state_ff == BK_RUN);
   end

   always_comb begin
      wp_in          = wp_ff;
      wrapped_in     = wrapped_ff;
      pending_in     = pending_ff;
      reason_in      = reason_ff;
      held_stamp_in  = held_stamp_ff;
      dump_active_in = dump_active_ff;
      next_chunk_in  = next_chunk_ff;
      chunk_total_in = chunk_total_ff;
      run_kind_in    = run_kind_ff;
      run_addr_in    = run_addr_ff;
      run_idx_in     = run_idx_ff;
      run_cnt_in     = run_cnt_ff;
      run_has_rec_in = run_has_rec_ff;
      run_total_in   = run_total_ff;
      run_chunk_in   = run_chunk_ff;
      run_more_in    = run_more_ff;
      mem_we         = 1'b0;

      if (emit) begin
         run_idx_in  = run_idx_ff + RUN_W'(1);
         run_addr_in = (run_addr_ff == PTR_W'(DEPTH - 1)) ? '0 : run_addr_ff + PTR_W'(1);
      end

      if (pop) begin
         // Most commands give one result without a record; the readouts override.
         run_idx_in     = '0;
         run_cnt_in     = RUN_W'(1);
         run_has_rec_in = 1'b0;
         run_total_in   = '0;
         run_chunk_in   = '0;
         run_more_in    = 1'b0;
         unique case (qr.entry.cmd)
            CMD_RECORD: begin
               mem_we = 1'b1;
               if (wp_ff == PTR_W'(DEPTH - 1)) begin
                  wp_in      = '0;
                  wrapped_in = 1'b1;
               end else begin
                  wp_in = wp_ff + PTR_W'(1);
               end
            end
            CMD_FAULT: begin
               pending_in    = 1'b1;
               reason_in     = qr.entry.reason;
               held_stamp_in = qr.entry.stamp;
               run_kind_in   = KIND_FAULT_ACK;
            end
            CMD_WINDOW: begin
               pending_in  = 1'b0;
               run_kind_in = KIND_WINDOW;
               if (take != '0) begin
                  run_cnt_in     = take;
                  run_has_rec_in = 1'b1;
                  run_total_in   = TOTAL_W'(take);
                  run_addr_in    = win_base;
               end
            end
            CMD_DUMP: begin
               chunk_total_in = dump_total;
               next_chunk_in  = '0;
               dump_active_in = (dump_total != '0);
               run_kind_in    = KIND_DUMP_START;
               run_total_in   = TOTAL_W'(dump_total);
               run_more_in    = (dump_total != '0);
            end
            CMD_CHUNK: begin
               if (!dump_active_ff) begin
                  run_kind_in = KIND_NOT_DUMPING;
               end else begin
                  run_kind_in   = KIND_DUMP_REC;
                  next_chunk_in = chunk_num;
                  if (!chunk_more) begin
                     dump_active_in = 1'b0;
                  end
                  run_total_in = TOTAL_W'(chunk_total_ff);
                  run_chunk_in = CHUNK_NUM_W'(chunk_num);
                  run_more_in  = chunk_more;
                  if (chunk_cnt != '0) begin
                     run_cnt_in     = chunk_cnt;
                     run_has_rec_in = 1'b1;
                     run_addr_in    = dump_base;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         wp_ff          <= '0;
         wrapped_ff     <= 1'b0;
         pending_ff     <= 1'b0;
         reason_ff      <= '0;
         held_stamp_ff  <= '0;
         dump_active_ff <= 1'b0;
         next_chunk_ff  <= '0;
         chunk_total_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wp_ff          <= wp_in;
         wrapped_ff     <= wrapped_in;
         pending_ff     <= pending_in;
         reason_ff      <= reason_in;
         held_stamp_ff  <= held_stamp_in;
         dump_active_ff <= dump_active_in;
         next_chunk_ff  <= next_chunk_in;
         chunk_total_ff <= chunk_total_in;
         out_valid_ff   <= emit;
      end
   end

   always_ff @(posedge clock) begin
      run_kind_ff    <= run_kind_in;
      run_addr_ff    <= run_addr_in;
      run_idx_ff     <= run_idx_in;
      run_cnt_ff     <= run_cnt_in;
      run_has_rec_ff <= run_has_rec_in;
      run_total_ff   <= run_total_in;
      run_chunk_ff   <= run_chunk_in;
      run_more_ff    <= run_more_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wp_ff] <= qr.entry.word;
      end
      rd_data_ff <= ring_mem[run_addr_ff];
   end

   // Result fields are registered alongside the memory read of the same entry.
   always_ff @(posedge clock) begin
      if (emit) begin
         out_meta_ff.kind           <= run_kind_ff;
         out_meta_ff.record_out     <= '0;
         out_meta_ff.record_valid   <= run_has_rec_ff;
         out_meta_ff.position       <= POS_W'(run_idx_ff);
         out_meta_ff.total_count    <= run_total_ff;
         out_meta_ff.chunk_number   <= run_chunk_ff;
         out_meta_ff.stored_count   <= STORED_W'(stored);
         out_meta_ff.latched_reason <= reason_ff;
         out_meta_ff.latched_time   <= held_stamp_ff;
         out_meta_ff.fault_pending  <= pending_ff;
         out_meta_ff.more_chunks    <= run_more_ff;
         out_meta_ff.last           <= run_last;
      end
   end

   assign rsp_strobe = out_valid_ff;

   always_comb begin
      rsp            = out_meta_ff;
      rsp.record_out = out_meta_ff.record_valid ? WORD_W'(rd_data_ff) : '0;
   end

endmodule

// ===== design/circular_trace_capture_readout.sv =====
// A readout or fault capture accepted into an empty queue with the back end idle is
// held in the queue, loaded into the run registers and issued through the registered
// output, then gives one result per cycle. Records are written one per cycle while the
// back end is idle; any other operation holds the back end from its pop to its last
// result, and busy rises when the two-entry queue fills. The receiver cannot stall;
// results are strobed for one cycle each. Reset (synchronous) clears pointers, flags,
// fault latch, dump state and queue; ring contents are left as they are.
module circular_trace_capture_readout (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ctcr_pkg::req_type req,
   output logic              busy,
   output logic              rsp_strobe,
   output ctcr_pkg::rsp_type rsp
);
   import ctcr_pkg::*;

   q_write_type qw;
   q_read_type  qr;
   logic        queue_full;
   logic        pop;

   ctcr_front u_front (
      .start      (start),
      .req        (req),
      .queue_full (queue_full),
      .busy       (busy),
      .qw         (qw)
   );

   ctcr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qw    (qw),
      .pop   (pop),
      .qr    (qr),
      .full  (queue_full)
   );

   ctcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qr         (qr),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

endmodule

// ===== design/ctcr_checker.sv =====
module ctcr_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input ctcr_pkg::req_type req,
   input logic              busy,
   input logic              rsp_strobe,
   input ctcr_pkg::rsp_type rsp
);
   import ctcr_pkg::*;

   // Nothing comes out and the block takes transfers right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("result strobe or busy right after reset");

   // A readout run delivers its results on consecutive cycles with rising positions.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.last |=>
         rsp_strobe && rsp.position == POS_W'($past(rsp.position) + POS_W'(1)))
      else $error("readout run broken or position skipped");

   a_run_same_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.last |=> rsp.kind == $past(rsp.kind)
         && rsp.total_count == $past(rsp.total_count))
      else $error("result kind or total changed inside a run");

   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.record_valid |-> rsp.last && rsp.record_out == '0)
      else $error("result without record is not a single final transfer");

   a_fault_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.kind == KIND_FAULT_ACK |-> rsp.fault_pending)
      else $error("fault acknowledge without pending flag");

endmodule

bind circular_trace_capture_readout ctcr_checker u_ctcr_checker (.*);
